// File: rtl/mvus_pkg.sv
// Shared constants and types for the MPEG-1 video unit splitter.
package mvus_pkg;

    // Width of one stream byte
    localparam int BYTE_W = 8;

    // Look-ahead window: holds four bytes, the oldest at index 0
    localparam int WINDOW_DEPTH = 4;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // A start code found less than this many bytes into a unit is ignored
    localparam int MIN_UNIT_LEN = 4;
    localparam int OFFSET_W     = $clog2(MIN_UNIT_LEN + 1);

    // Start code bytes: 00 00 01 then one of the recognized codes
    localparam logic [BYTE_W-1:0] SC_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ONE      = 8'h01;
    localparam logic [BYTE_W-1:0] SC_PICTURE  = 8'h00;
    localparam logic [BYTE_W-1:0] SC_SEQ_HDR  = 8'hb3;
    localparam logic [BYTE_W-1:0] SC_GOP      = 8'hb8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef t_byte t_window [WINDOW_DEPTH];

endpackage

// File: rtl/mvus_if.sv
// Handshake channels of the unit splitter: raw stream in, unit bytes out.
interface mvus_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mvus_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] unit_byte;
    logic       unit_first;
    logic       unit_last;

    modport source (output valid, output unit_byte, output unit_first,
                    output unit_last, input ready);
    modport sink   (input valid, input unit_byte, input unit_first,
                    input unit_last, output ready);
endinterface

// File: rtl/mpeg1_video_unit_splitter.sv
// Top level of the MPEG-1 video unit splitter.
//
// Usage:
//   i_in carries the raw video elementary stream, one byte per beat.
//   o_out carries the bytes of each unit with first/last flags. A unit
//   starts at a start code 00 00 01 xx (xx = 00, B3 or B8) and ends at
//   the byte before the next one; bytes ahead of the first start code
//   are dropped. A start code less than four bytes into a unit is data.
// Latency and throughput:
//   One byte accepted per cycle unless o_out stalls. A byte comes out with
//   the beat that accepts the fourth byte after it, and is valid on o_out
//   the cycle after that edge. The rate is set by the single output
//   register; the window compare is one level of byte matching.
// Reset:
//   Fill count and unit tracking clear, the window does not; the first
//   four bytes only fill the window. The last unit is never closed: its
//   final four bytes stay in the window until more input arrives.
// Stall:
//   When o_out.ready is low with a beat pending, i_in.ready drops and the
//   window holds; nothing is lost or repeated.
module mpeg1_video_unit_splitter
    import mvus_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mvus_in_if.sink            i_in,
    mvus_out_if.source         o_out
);

    t_window               r_window;
    t_window               n_window;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic                  r_inside;
    logic                  n_inside;
    logic [OFFSET_W-1:0]   r_offset;
    logic [OFFSET_W-1:0]   n_offset;
    logic                  r_out_valid;
    t_byte                 r_out_byte;
    logic                  r_out_first;
    logic                  r_out_last;

    logic                  accept;
    logic                  window_full;
    logic                  is_sc;
    logic                  emit;
    logic                  last;
    logic [OFFSET_W-1:0]   bumped_offset;

    // Take a byte whenever the output register is free or draining
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign window_full = (r_fill == FILL_W'(WINDOW_DEPTH));

    // Shift the new byte into the window; during fill this lands the
    // bytes in arrival order just the same
    always_comb begin
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            n_window[k] = r_window[k + 1];
        end
        n_window[WINDOW_DEPTH - 1] = i_in.stream_byte;
    end

    mvus_sc_detect u_sc_detect (
        .i_window        (n_window),
        .o_is_start_code (is_sc)
    );

    // Saturating position of the leaving byte's successor within its unit
    assign bumped_offset = (r_offset >= OFFSET_W'(MIN_UNIT_LEN - 1)) ?
                           OFFSET_W'(MIN_UNIT_LEN) : r_offset + OFFSET_W'(1);

    // Unit tracking
    always_comb begin
        n_fill   = r_fill;
        n_inside = r_inside;
        n_offset = r_offset;
        last     = 1'b0;
        emit     = 1'b0;
        if (accept) begin
            if (!window_full) begin
                n_fill = r_fill + FILL_W'(1);
                if (r_fill == FILL_W'(WINDOW_DEPTH - 1) && is_sc) begin
                    n_inside = 1'b1;
                    n_offset = '0;
                end
            end else if (r_inside) begin
                emit     = 1'b1;
                n_offset = bumped_offset;
                if (bumped_offset == OFFSET_W'(MIN_UNIT_LEN) && is_sc) begin
                    last     = 1'b1;
                    n_offset = '0;
                end
            end else if (is_sc) begin
                n_inside = 1'b1;
                n_offset = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_inside    <= 1'b0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_inside <= n_inside;
            r_offset <= n_offset;
            if (accept) begin
                r_out_valid <= emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
        if (accept && emit) begin
            r_out_byte  <= r_window[0];
            r_out_first <= (r_offset == '0);
            r_out_last  <= last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.unit_byte  = r_out_byte;
    assign o_out.unit_first = r_out_first;
    assign o_out.unit_last  = r_out_last;

endmodule

// File: rtl/mvus_sc_detect.sv
// Start code matcher over the four-byte look-ahead window.
module mvus_sc_detect
    import mvus_pkg::*;
(
    input  t_window i_window,
    output logic    o_is_start_code
);

    logic prefix_hit;
    logic code_hit;

    // 00 00 01 prefix in the three oldest bytes
    assign prefix_hit = (i_window[0] == SC_ZERO) && (i_window[1] == SC_ZERO) &&
                        (i_window[2] == SC_ONE);

    // Only picture, sequence header and GOP codes open a unit
    assign code_hit = (i_window[3] == SC_PICTURE) || (i_window[3] == SC_SEQ_HDR) ||
                      (i_window[3] == SC_GOP);

    assign o_is_start_code = prefix_hit && code_hit;

endmodule
